// ===== design/flgg_pkg.sv =====
// Shared types and constants for the facility-location greedy gain unit.
// Used by flgg_ctrl, flgg_datapath and the top level; no dependencies.
`default_nettype none

package flgg_pkg;

    localparam int DEF_MAX_ELEMENTS = 64;

    // Field widths of the stream items and the configuration register
    localparam int OP_W     = 2;
    localparam int FIELD_W  = 6;
    localparam int WEIGHT_W = 32;
    localparam int SUM_W    = 48;
    localparam int ACT_W    = 7;

    localparam int S_TDATA_W = 48;   // 46 bits of fields, padded to whole bytes
    localparam int M_TDATA_W = 104;  // 102 bits of fields, padded to whole bytes

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_WEIGHT  = 2'd0,
        OP_WRITE_MODULAR = 2'd1,
        OP_START         = 2'd2,
        OP_ADD_ELEMENT   = 2'd3
    } op_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;  // input transaction taken this cycle
        logic load;    // seed the gain accumulator with the modular weight
        logic issue;   // read the next row of the element's column
        logic finish;  // commit the gain and load the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic issue_done;  // every active row has been read
        logic pipe_busy;   // a row is still in the compare stage
        logic out_free;    // output register can take a new result
    } sts_t;

endpackage

`default_nettype wire

// ===== design/flgg_ctrl.sv =====
// Sequencer for the greedy gain unit: accepts items, walks the active rows.
// Depends on flgg_pkg; drives the command struct read by flgg_datapath.
`default_nettype none

module flgg_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire flgg_pkg::op_t in_op,
    input  wire flgg_pkg::sts_t sts,
    output flgg_pkg::cmd_t     cmd
);
    import flgg_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_tvalid;
                if (s_tvalid && (in_op == OP_ADD_ELEMENT)) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.issue = !sts.issue_done;
                if (sts.issue_done && !sts.pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the result until the output register frees up
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/flgg_datapath.sv =====
// Datapath of the greedy gain unit: weight and modular memories, row maxima,
// the compare-and-accumulate stage, running total and output register.
// Depends on flgg_pkg; driven by the command struct from flgg_ctrl.
`default_nettype none

module flgg_datapath #(
    parameter int MAX_ELEMENTS = flgg_pkg::DEF_MAX_ELEMENTS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire flgg_pkg::cmd_t                     cmd,
    output flgg_pkg::sts_t                          sts,
    input  wire logic                               cfg_valid,
    input  wire logic [flgg_pkg::ACT_W-1:0]         cfg_data,
    input  wire flgg_pkg::op_t                      in_op,
    input  wire logic [flgg_pkg::FIELD_W-1:0]       in_row,
    input  wire logic [flgg_pkg::FIELD_W-1:0]       in_element,
    input  wire logic signed [flgg_pkg::WEIGHT_W-1:0] in_weight,
    input  wire logic                               in_last,
    input  wire logic                               m_tready,
    output logic                                    out_valid,
    output logic [flgg_pkg::FIELD_W-1:0]            out_element,
    output logic signed [flgg_pkg::SUM_W-1:0]       out_gain,
    output logic signed [flgg_pkg::SUM_W-1:0]       out_prefix,
    output logic                                    out_last
);
    import flgg_pkg::*;

    localparam int IDX_W   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
    localparam int DEPTH   = MAX_ELEMENTS * MAX_ELEMENTS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIFF_W  = WEIGHT_W + 1;

    // Storage
    logic signed [WEIGHT_W-1:0] weight_mem  [DEPTH];
    logic signed [WEIGHT_W-1:0] modular_mem [MAX_ELEMENTS];
    logic signed [WEIGHT_W-1:0] rmax_mem    [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0]    rmax_valid_reg;

    // Item context
    logic [ACT_W-1:0]          active_reg;
    logic [FIELD_W-1:0]        el_reg;
    logic                      last_reg;
    logic                      inside_reg;
    logic [CNT_W-1:0]          row_cnt_reg;
    logic [CNT_W-1:0]          rows;

    // Read stage outputs
    logic signed [WEIGHT_W-1:0] mod_q_reg;
    logic signed [WEIGHT_W-1:0] w_q_reg;
    logic signed [WEIGHT_W-1:0] rmax_q_reg;
    logic                       rvalid_q_reg;
    logic [IDX_W-1:0]           row_q_reg;
    logic                       p1_valid_reg;

    logic signed [SUM_W-1:0]    acc_reg;
    logic signed [SUM_W-1:0]    acc_next;
    logic signed [SUM_W-1:0]    total_reg;
    logic signed [SUM_W-1:0]    total_next;

    logic                       out_valid_reg;
    logic [FIELD_W-1:0]         out_element_reg;
    logic signed [SUM_W-1:0]    out_gain_reg;
    logic signed [SUM_W-1:0]    out_prefix_reg;
    logic                       out_last_reg;

    logic                       row_ok;
    logic                       el_ok;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr;
    logic [IDX_W-1:0]           scan_idx;

    logic signed [WEIGHT_W-1:0] w_eff;
    logic signed [WEIGHT_W-1:0] m_eff;
    logic                       rise;
    logic signed [DIFF_W-1:0]   diff;

    assign row_ok   = (int'(in_row) < MAX_ELEMENTS);
    assign el_ok    = (int'(in_element) < MAX_ELEMENTS);
    assign wr_addr  = ADDR_W'(int'(in_row) * MAX_ELEMENTS + int'(in_element));
    assign scan_idx = row_cnt_reg[IDX_W-1:0];
    assign rd_addr  = ADDR_W'(int'(scan_idx) * MAX_ELEMENTS + int'(el_reg));
    assign rows     = (int'(active_reg) > MAX_ELEMENTS) ? CNT_W'(MAX_ELEMENTS)
                                                         : CNT_W'(active_reg);

    // Compare stage: a row maximum that was never raised since start reads as zero
    assign w_eff    = inside_reg ? w_q_reg : '0;
    assign m_eff    = rvalid_q_reg ? rmax_q_reg : '0;
    assign rise     = w_eff > m_eff;
    assign diff     = DIFF_W'(w_eff) - DIFF_W'(m_eff);

    always_comb begin
        acc_next = acc_reg;
        if (cmd.load) begin
            acc_next = inside_reg ? SUM_W'(mod_q_reg) : '0;
        end else if (p1_valid_reg && rise) begin
            acc_next = acc_reg + SUM_W'(diff);
        end
    end

    assign total_next = total_reg + acc_reg;

    // Memories
    always_ff @(posedge aclk) begin
        if (cmd.accept && (in_op == OP_WRITE_WEIGHT) && row_ok && el_ok) begin
            weight_mem[wr_addr] <= in_weight;
        end
        if (cmd.accept && (in_op == OP_WRITE_MODULAR) && el_ok) begin
            modular_mem[IDX_W'(in_element)] <= in_weight;
        end
        if (p1_valid_reg && rise) begin
            rmax_mem[row_q_reg] <= w_eff;
        end
        w_q_reg    <= weight_mem[rd_addr];
        rmax_q_reg <= rmax_mem[scan_idx];
        mod_q_reg  <= modular_mem[IDX_W'(in_element)];
    end

    // Item context and read stage bookkeeping
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            el_reg     <= in_element;
            last_reg   <= in_last;
            inside_reg <= el_ok;
        end
        if (cmd.accept) begin
            row_cnt_reg <= '0;
        end else if (cmd.issue) begin
            row_cnt_reg <= row_cnt_reg + CNT_W'(1);
        end
        rvalid_q_reg <= rmax_valid_reg[scan_idx];
        row_q_reg    <= scan_idx;
        acc_reg      <= acc_next;
        if (cmd.finish) begin
            out_element_reg <= el_reg;
            out_gain_reg    <= acc_reg;
            out_prefix_reg  <= total_next;
            out_last_reg    <= last_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= ACT_W'(64);
            rmax_valid_reg <= '0;
            total_reg      <= '0;
            p1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                active_reg <= cfg_data;
            end
            if (cmd.accept && (in_op == OP_START)) begin
                rmax_valid_reg <= '0;
                total_reg      <= '0;
            end else begin
                if (p1_valid_reg && rise) begin
                    rmax_valid_reg[row_q_reg] <= 1'b1;
                end
                if (cmd.finish) begin
                    total_reg <= total_next;
                end
            end
            p1_valid_reg <= cmd.issue;
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.issue_done = (row_cnt_reg == rows);
    assign sts.pipe_busy  = p1_valid_reg;
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign out_valid   = out_valid_reg;
    assign out_element = out_element_reg;
    assign out_gain    = out_gain_reg;
    assign out_prefix  = out_prefix_reg;
    assign out_last    = out_last_reg;

endmodule

`default_nettype wire

// ===== design/facility_location_greedy_gain_unit.sv =====
// Top level of the facility-location greedy gain unit.
// Depends on flgg_pkg, flgg_ctrl and flgg_datapath.
`default_nettype none

// Weight, modular-weight and start items are taken in the idle state and
// need no further steps. An add-element item goes through accept, accumulator
// seed, a scan over rows = min(active_size, MAX_ELEMENTS) rows, a drain of the
// compare stage and result commit: the scan reads one matrix row of the
// element's column per cycle through the weight memory's single read port and
// folds it into that row's running maximum. A finished result waits in the
// output register while the next item is taken; an add-element item stalls in
// its commit step only if that register is still full. The row maxima are
// cleared at once by a start item, no clearing pass.
module facility_location_greedy_gain_unit #(
    parameter int MAX_ELEMENTS = flgg_pkg::DEF_MAX_ELEMENTS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [flgg_pkg::ACT_W-1:0]         cfg_data,   // active_size
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // operation[1:0], row[7:2], element[13:8], weight_value[45:14], zero pad
    input  wire logic [flgg_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                               s_tlast,    // is_last
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // out_element[5:0], gain[53:6], prefix_value[101:54], zero pad
    output logic [flgg_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                    m_tlast     // out_last
);
    import flgg_pkg::*;

    cmd_t                       cmd;
    sts_t                       sts;
    op_t                        in_op;
    logic [FIELD_W-1:0]         out_element;
    logic signed [SUM_W-1:0]    out_gain;
    logic signed [SUM_W-1:0]    out_prefix;

    assign in_op     = op_t'(s_tdata[OP_W-1:0]);
    assign cfg_ready = 1'b1;

    flgg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_op    (in_op),
        .sts      (sts),
        .cmd      (cmd)
    );

    flgg_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .in_op       (in_op),
        .in_row      (s_tdata[OP_W +: FIELD_W]),
        .in_element  (s_tdata[OP_W + FIELD_W +: FIELD_W]),
        .in_weight   (s_tdata[OP_W + 2*FIELD_W +: WEIGHT_W]),
        .in_last     (s_tlast),
        .m_tready    (m_tready),
        .out_valid   (m_tvalid),
        .out_element (out_element),
        .out_gain    (out_gain),
        .out_prefix  (out_prefix),
        .out_last    (m_tlast)
    );

    assign m_tdata = {(M_TDATA_W - FIELD_W - 2*SUM_W)'(0), out_prefix, out_gain, out_element};

endmodule

`default_nettype wire

// ===== tb/tb_facility_location_greedy_gain_unit.sv =====
// Self-checking testbench for facility_location_greedy_gain_unit: directed rows, then
// random orderings with random stalls on both streams, checked against a local predictor.
// Depends on flgg_pkg and the RTL of the unit; nothing else.
module tb_facility_location_greedy_gain_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import flgg_pkg::*;

    localparam int ROWS_MAX      = DEF_MAX_ELEMENTS;
    localparam int SCAN_LATENCY  = ROWS_MAX + 16;
    localparam int STUCK_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 12;

    localparam logic signed [SUM_W-1:0] W_MAX = 48'sd2147483647;
    localparam logic signed [SUM_W-1:0] W_MIN = -48'sd2147483648;
    localparam logic signed [SUM_W-1:0] ONE   = 48'sd65536;
    localparam logic signed [SUM_W-1:0] FULL1 = ONE + 64 * W_MAX;

    typedef struct packed {
        logic [FIELD_W-1:0]        element;
        logic signed [SUM_W-1:0]   gain;
        logic signed [SUM_W-1:0]   prefix;
        logic                      last;
    } gain_result_t;

    typedef struct packed {
        logic                      is_cfg;
        op_t                       op;
        logic [FIELD_W-1:0]        row;
        logic [FIELD_W-1:0]        el;
        logic [WEIGHT_W-1:0]       wv;
        logic                      last;
        logic                      typed;
        logic signed [SUM_W-1:0]   t_gain;
        logic signed [SUM_W-1:0]   t_prefix;
    } dir_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [ACT_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    // Predictor state
    logic signed [WEIGHT_W-1:0] weight_mem [ROWS_MAX][ROWS_MAX];
    logic signed [WEIGHT_W-1:0] modular_mem [ROWS_MAX];
    logic signed [WEIGHT_W-1:0] row_max [ROWS_MAX];
    logic signed [SUM_W-1:0]    prefix_sum;
    logic [ACT_W-1:0]           active_size;
    bit                         weight_set [ROWS_MAX][ROWS_MAX];
    bit                         modular_set [ROWS_MAX];

    gain_result_t   gain_q [$];
    dir_row_t       dir_tab [$];
    bit             typed_pending;
    logic signed [SUM_W-1:0] typed_gain;
    logic signed [SUM_W-1:0] typed_prefix;

    int  fails;
    int  items_sent;
    int  stuck_cycles;
    bit  no_gaps;
    bit  hold_req;

    facility_location_greedy_gain_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int scan_rows();
        return (active_size > ROWS_MAX) ? ROWS_MAX : int'(active_size);
    endfunction

    // Fold one accepted transaction into the predictor; queue the gain if it makes one.
    function automatic void predict_gain(op_t op, logic [FIELD_W-1:0] row,
                                         logic [FIELD_W-1:0] el, logic [WEIGHT_W-1:0] wv,
                                         logic last);
        gain_result_t            r;
        logic signed [SUM_W-1:0] w48;
        logic signed [SUM_W-1:0] m48;
        case (op)
            OP_WRITE_WEIGHT: begin
                weight_mem[row][el] = wv;
                weight_set[row][el] = 1'b1;
            end
            OP_WRITE_MODULAR: begin
                modular_mem[el] = wv;
                modular_set[el] = 1'b1;
            end
            OP_START: begin
                foreach (row_max[j]) row_max[j] = '0;
                prefix_sum = '0;
            end
            OP_ADD_ELEMENT: begin
                m48 = modular_mem[el];
                r.gain = m48;
                for (int j = 0; j < scan_rows(); j++) begin
                    if (weight_mem[j][el] > row_max[j]) begin
                        w48 = weight_mem[j][el];
                        m48 = row_max[j];
                        r.gain = r.gain + w48 - m48;
                        row_max[j] = weight_mem[j][el];
                    end
                end
                prefix_sum = prefix_sum + r.gain;
                r.element = el;
                r.prefix = prefix_sum;
                r.last = last;
                if (typed_pending) begin
                    r.gain = typed_gain;
                    r.prefix = typed_prefix;
                end
                gain_q.push_back(r);
            end
        endcase
        typed_pending = 1'b0;
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3, 4:    return $urandom_range(0, 32'h000F_FFFF);
            5:       return -$urandom_range(1, 32'h000F_FFFF);
            default: return $urandom();
        endcase
    endfunction

    // Only columns whose active rows and modular entry are written may be added.
    function automatic bit column_ready(int col);
        if (!modular_set[col]) return 1'b0;
        for (int r = 0; r < scan_rows(); r++)
            if (!weight_set[r][col]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic int pick_ready();
        int base;
        base = $urandom_range(0, ROWS_MAX - 1);
        for (int k = 0; k < ROWS_MAX; k++)
            if (column_ready((base + k) % ROWS_MAX)) return (base + k) % ROWS_MAX;
        return -1;
    endfunction

    task automatic send(input op_t op, input logic [FIELD_W-1:0] row,
                        input logic [FIELD_W-1:0] el, input logic [WEIGHT_W-1:0] wv,
                        input logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, wv, el, row, op};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_gain(op, row, el, wv, last);
        items_sent++;
    endtask

    task automatic fill_column(input int col);
        for (int r = 0; r < scan_rows(); r++)
            send(OP_WRITE_WEIGHT, 6'(r), 6'(col), rand_weight(), 1'($urandom()));
        send(OP_WRITE_MODULAR, 6'($urandom()), 6'(col), rand_weight(), 1'($urandom()));
    endtask

    task automatic add_ready(input logic last);
        int col;
        col = pick_ready();
        if (col < 0 || $urandom_range(0, 5) == 0) begin
            col = $urandom_range(0, ROWS_MAX - 1);
            fill_column(col);
        end
        send(OP_ADD_ELEMENT, 6'($urandom()), 6'(col), $urandom(), last);
    endtask

    // Write active_size only once the unit has drained.
    task automatic set_active(input logic [ACT_W-1:0] v);
        s_tvalid <= 1'b0;
        while (gain_q.size() != 0) @(posedge aclk);
        repeat (SCAN_LATENCY) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        active_size = v;
    endtask

    task automatic tab(input logic is_cfg, input op_t op, input logic [FIELD_W-1:0] row,
                       input logic [FIELD_W-1:0] el, input logic [WEIGHT_W-1:0] wv,
                       input logic last, input logic typed,
                       input logic signed [SUM_W-1:0] tg, input logic signed [SUM_W-1:0] tp);
        dir_row_t d;
        d = '{is_cfg, op, row, el, wv, last, typed, tg, tp};
        dir_tab.push_back(d);
    endtask

    // Result side: random stalls, one long hold-off on request, check each transaction.
    initial begin
        int           stall;
        gain_result_t want;
        logic [FIELD_W-1:0]      got_el;
        logic signed [SUM_W-1:0] got_gain;
        logic signed [SUM_W-1:0] got_prefix;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req) begin
                stall = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = no_gaps ? 0 : $urandom_range(0, 4);
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got_el     = m_tdata[5:0];
            got_gain   = m_tdata[53:6];
            got_prefix = m_tdata[101:54];
            if (gain_q.size() == 0) begin
                $error("unexpected result: element %0d gain %0d", got_el, got_gain);
                fails++;
            end else begin
                want = gain_q.pop_front();
                if (got_el !== want.element) begin
                    $error("out_element: expected %0d, actual %0d", want.element, got_el);
                    fails++;
                end
                if (got_gain !== want.gain) begin
                    $error("gain: expected %0d, actual %0d", want.gain, got_gain);
                    fails++;
                end
                if (got_prefix !== want.prefix) begin
                    $error("prefix_value: expected %0d, actual %0d", want.prefix, got_prefix);
                    fails++;
                end
                if (m_tlast !== want.last) begin
                    $error("out_last: expected %0d, actual %0d", want.last, m_tlast);
                    fails++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        int n;
        int choice;
        int start_count;
        bit hold_done;
        logic [ACT_W-1:0] act_sel;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        fails = 0;
        items_sent = 0;
        no_gaps = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        typed_pending = 1'b0;
        prefix_sum = '0;
        active_size = 7'd64;
        foreach (row_max[j]) row_max[j] = '0;
        foreach (modular_set[j]) modular_set[j] = 1'b0;
        foreach (weight_set[r, c]) weight_set[r][c] = 1'b0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Columns 0..3 over every row: all zero, all max, all min, random
        for (int r = 0; r < ROWS_MAX; r++) begin
            send(OP_WRITE_WEIGHT, 6'(r), 6'd0, 32'h0000_0000, 1'b0);
            send(OP_WRITE_WEIGHT, 6'(r), 6'd1, 32'h7FFF_FFFF, 1'b1);
            send(OP_WRITE_WEIGHT, 6'(r), 6'd2, 32'h8000_0000, 1'b0);
            send(OP_WRITE_WEIGHT, 6'(r), 6'd3, rand_weight(), 1'b1);
        end

        tab(0, OP_WRITE_MODULAR, 6'd0, 6'd0, 32'h0000_0000, 0, 0, 0, 0);
        tab(0, OP_WRITE_MODULAR, 6'd0, 6'd1, 32'h0001_0000, 0, 0, 0, 0);
        tab(0, OP_WRITE_MODULAR, 6'd0, 6'd2, 32'h8000_0000, 0, 0, 0, 0);
        tab(0, OP_WRITE_MODULAR, 6'd0, 6'd3, 32'h7FFF_FFFF, 0, 0, 0, 0);
        // no start item yet: maxima and prefix hold their reset values
        tab(0, OP_ADD_ELEMENT, 6'd0, 6'd0, 32'h0, 0, 1, 0, 0);
        tab(0, OP_ADD_ELEMENT, 6'd0, 6'd1, 32'h0, 0, 1, FULL1, FULL1);
        tab(0, OP_ADD_ELEMENT, 6'd0, 6'd1, 32'h0, 0, 1, ONE, FULL1 + ONE);
        tab(0, OP_ADD_ELEMENT, 6'd0, 6'd2, 32'h0, 1, 1, W_MIN, FULL1 + ONE + W_MIN);
        tab(0, OP_START, 6'd63, 6'd63, 32'hFFFF_FFFF, 1, 0, 0, 0);
        tab(0, OP_ADD_ELEMENT, 6'd0, 6'd2, 32'h0, 0, 1, W_MIN, W_MIN);
        tab(0, OP_ADD_ELEMENT, 6'd63, 6'd3, 32'hFFFF_FFFF, 1, 0, 0, 0);
        tab(0, OP_WRITE_WEIGHT, 6'd63, 6'd63, 32'hFFFF_FFFF, 1, 0, 0, 0);
        tab(1, OP_START, 6'd0, 6'd0, 32'd1, 0, 0, 0, 0);
        tab(0, OP_START, 6'd0, 6'd0, 32'h0, 0, 0, 0, 0);
        tab(0, OP_ADD_ELEMENT, 6'd0, 6'd1, 32'h0, 0, 1, ONE + W_MAX, ONE + W_MAX);
        tab(0, OP_ADD_ELEMENT, 6'd0, 6'd3, 32'h0, 1, 1, W_MAX, ONE + 2 * W_MAX);
        // zero active rows: gain is the modular weight alone
        tab(1, OP_START, 6'd0, 6'd0, 32'd0, 0, 0, 0, 0);
        tab(0, OP_START, 6'd0, 6'd0, 32'h0, 0, 0, 0, 0);
        tab(0, OP_ADD_ELEMENT, 6'd0, 6'd2, 32'h0, 0, 1, W_MIN, W_MIN);
        tab(0, OP_ADD_ELEMENT, 6'd0, 6'd1, 32'h0, 1, 1, ONE, W_MIN + ONE);
        // oversized active size clamps to the full matrix
        tab(1, OP_START, 6'd0, 6'd0, 32'd127, 0, 0, 0, 0);
        tab(0, OP_START, 6'd0, 6'd0, 32'h0, 0, 0, 0, 0);
        tab(0, OP_ADD_ELEMENT, 6'd0, 6'd1, 32'h0, 0, 1, FULL1, FULL1);
        tab(0, OP_ADD_ELEMENT, 6'd0, 6'd0, 32'h0, 1, 1, 0, FULL1);
        tab(1, OP_START, 6'd0, 6'd0, 32'd64, 0, 0, 0, 0);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                set_active(dir_tab[i].wv[ACT_W-1:0]);
            end else begin
                typed_pending = dir_tab[i].typed;
                typed_gain    = dir_tab[i].t_gain;
                typed_prefix  = dir_tab[i].t_prefix;
                send(dir_tab[i].op, dir_tab[i].row, dir_tab[i].el, dir_tab[i].wv,
                     dir_tab[i].last);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       act_sel = 7'd3;
                1:       act_sel = 7'd1;
                2:       act_sel = 7'd64;
                3:       act_sel = 7'($urandom_range(4, 16));
                4:       act_sel = 7'd2;
                default: act_sel = 7'($urandom_range(1, 64));
            endcase
            set_active(act_sel);
            no_gaps = (ph == 1);
            start_count = items_sent;
            while (items_sent - start_count < PHASE_ITEMS) begin
                choice = hold_done ? $urandom_range(0, 9) : 2;
                if (choice < 2) begin
                    fill_column($urandom_range(0, ROWS_MAX - 1));
                end else if (choice < 8) begin
                    // well-formed ordering; the first one in phase 0 runs into a long hold-off
                    if (!hold_done) begin
                        hold_req = 1'b1;
                        hold_done = 1'b1;
                        n = 12;
                    end else begin
                        n = $urandom_range(1, 8);
                    end
                    send(OP_START, 6'($urandom()), 6'($urandom()), $urandom(),
                         1'($urandom()));
                    for (int k = 0; k < n; k++) add_ready(k == n - 1);
                end else if (choice == 8) begin
                    send($urandom_range(0, 1) ? OP_WRITE_MODULAR : OP_WRITE_WEIGHT,
                         6'($urandom()), 6'($urandom()), rand_weight(), 1'($urandom()));
                end else begin
                    // adds with no start in front, last flag at random
                    n = $urandom_range(1, 3);
                    for (int k = 0; k < n; k++) add_ready(1'($urandom()));
                end
            end
        end

        s_tvalid <= 1'b0;
        no_gaps = 1'b0;
        while (gain_q.size() != 0) @(posedge aclk);
        repeat (SCAN_LATENCY) @(posedge aclk);
        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/flgg_pkg.sv
design/flgg_ctrl.sv
design/flgg_datapath.sv
design/facility_location_greedy_gain_unit.sv
tb/tb_facility_location_greedy_gain_unit.sv
